/* rtl/bmm_pkg.sv */
// bmm_pkg: constants, command codes and memory request type for the banked memory mapper.
// No dependencies; imported by bmm_store and banked_memory_mapper.
package bmm_pkg;

    localparam int PAGE_BYTES = 16384;
    localparam int RAM_BANKS  = 8;
    localparam int ROM_BANKS  = 2;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int OFF_W     = $clog2(PAGE_BYTES);
    localparam int WIN_W     = ADDR_W - OFF_W;
    localparam int BANK_W    = $clog2(RAM_BANKS);
    localparam int ROMB_W    = $clog2(ROM_BANKS);
    localparam int RAM_AW    = BANK_W + OFF_W;
    localparam int ROM_AW    = ROMB_W + OFF_W;
    localparam int RAM_DEPTH = RAM_BANKS * PAGE_BYTES;
    localparam int ROM_DEPTH = ROM_BANKS * PAGE_BYTES;
    localparam int ULA_W     = 5;

    localparam logic [ADDR_W-1:0] PAGING_PORT = 16'h7FFD;

    localparam int LOCK_BIT   = 5;
    localparam int ROMSEL_BIT = 4;
    localparam int SCREEN_BIT = 3;
    localparam int EAR_BIT    = 4;
    localparam int MIC_BIT    = 3;

    localparam logic [BANK_W-1:0] BANK_WIN1  = 3'd5;
    localparam logic [BANK_W-1:0] BANK_WIN2  = 3'd2;
    localparam logic [BANK_W-1:0] SCREEN_LO  = 3'd5;
    localparam logic [BANK_W-1:0] SCREEN_HI  = 3'd7;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PORT  = 2'd2,
        CMD_LOAD  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              ram_we;
        logic              ram_re;
        logic              rom_we;
        logic              rom_re;
        logic [RAM_AW-1:0] ram_addr;
        logic [ROM_AW-1:0] rom_addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

endpackage

/* rtl/bmm_store.sv */
// bmm_store: RAM and ROM byte stores, one port each, registered read data.
// Depends on bmm_pkg.
module bmm_store (
    input  logic                          clk,
    input  bmm_pkg::mem_req_t             req,
    output logic [bmm_pkg::DATA_W-1:0]    ram_q,
    output logic [bmm_pkg::DATA_W-1:0]    rom_q
);
    import bmm_pkg::*;

    logic [DATA_W-1:0] ram_mem [RAM_DEPTH];
    logic [DATA_W-1:0] rom_mem [ROM_DEPTH];
    logic [DATA_W-1:0] ram_q_reg;
    logic [DATA_W-1:0] rom_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.ram_we)
        begin
            ram_mem[req.ram_addr] <= req.wdata;
        end
        if (req.ram_re)
        begin
            ram_q_reg <= ram_mem[req.ram_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rom_we)
        begin
            rom_mem[req.rom_addr] <= req.wdata;
        end
        if (req.rom_re)
        begin
            rom_q_reg <= rom_mem[req.rom_addr];
        end
    end

    assign ram_q = ram_q_reg;
    assign rom_q = rom_q_reg;

endmodule

/* rtl/banked_memory_mapper.sv */
// banked_memory_mapper: top level; decodes bus words into the paged RAM/ROM and port latches.
// Depends on bmm_pkg and bmm_store.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   req     | req_valid/req_ready  | cmd, address, wdata
//   rsp     | rsp_valid/rsp_ready  | rdata, contended, rom_bank, ram_bank, screen_bank,
//           |                      | paging_locked, border_color, ear_bit, mic_bit
//
// One word per cycle while rsp_ready is held high; each result appears the cycle after its word is taken.
// The single store port per memory, read into its output register, sets that figure.
// A word is taken while the result register is empty or being emptied in the same cycle.
// Reset clears the paging and port latches; store contents are not cleared.
module banked_memory_mapper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [1:0]                      cmd,
    input  logic [bmm_pkg::ADDR_W-1:0]      address,
    input  logic [bmm_pkg::DATA_W-1:0]      wdata,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [bmm_pkg::DATA_W-1:0]      rdata,
    output logic                            contended,
    output logic                            rom_bank,
    output logic [bmm_pkg::BANK_W-1:0]      ram_bank,
    output logic [bmm_pkg::BANK_W-1:0]      screen_bank,
    output logic                            paging_locked,
    output logic [2:0]                      border_color,
    output logic                            ear_bit,
    output logic                            mic_bit
);
    import bmm_pkg::*;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_RAM,
        RD_ROM
    } rd_sel_t;

    cmd_t              cmd_c;
    logic              accept;
    logic [WIN_W-1:0]  win;
    logic [OFF_W-1:0]  off;
    logic [BANK_W-1:0] win_bank;
    logic              ram_win;
    logic              rom_win;
    logic              cont_c;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] rom_q;

    logic              valid_reg;
    logic              rom_sel_reg, rom_sel_next;
    logic [BANK_W-1:0] ram_sel_reg, ram_sel_next;
    logic [BANK_W-1:0] screen_reg, screen_next;
    logic              lock_reg, lock_next;
    logic [ULA_W-1:0]  ula_reg, ula_next;
    rd_sel_t           rd_sel_reg, rd_sel_next;
    logic              contended_reg;

    assign cmd_c     = cmd_t'(cmd);
    assign req_ready = !valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign win       = address[ADDR_W-1:OFF_W];
    assign off       = address[OFF_W-1:0];
    assign rom_win   = (win == WIN_W'(0));
    assign ram_win   = (win == WIN_W'(1)) || (win == WIN_W'(2)) || (win == WIN_W'(3));

    always_comb
    begin
        if (win == WIN_W'(1))
        begin
            win_bank = BANK_WIN1;
        end
        else if (win == WIN_W'(2))
        begin
            win_bank = BANK_WIN2;
        end
        else
        begin
            win_bank = ram_sel_reg;
        end
    end

    // contention judged on the banks in force before this word
    assign cont_c = (cmd_c != CMD_LOAD)
                 && ((win == WIN_W'(1)) || ((win == WIN_W'(3)) && ram_sel_reg[0]));

    always_comb
    begin
        mem_req.ram_we   = accept && (cmd_c == CMD_WRITE) && ram_win;
        mem_req.ram_re   = accept && (cmd_c == CMD_READ) && ram_win;
        mem_req.rom_we   = accept && (cmd_c == CMD_LOAD);
        mem_req.rom_re   = accept && (cmd_c == CMD_READ) && rom_win;
        mem_req.ram_addr = {win_bank, off};
        mem_req.rom_addr = (cmd_c == CMD_LOAD) ? address[ROM_AW-1:0] : {rom_sel_reg, off};
        mem_req.wdata    = wdata;
    end

    always_comb
    begin
        rom_sel_next = rom_sel_reg;
        ram_sel_next = ram_sel_reg;
        screen_next  = screen_reg;
        lock_next    = lock_reg;
        ula_next     = ula_reg;
        rd_sel_next  = RD_ZERO;
        case (cmd_c)
            CMD_READ:
            begin
                if (rom_win)
                begin
                    rd_sel_next = RD_ROM;
                end
                else if (ram_win)
                begin
                    rd_sel_next = RD_RAM;
                end
            end
            CMD_PORT:
            begin
                if (!address[0])
                begin
                    ula_next = wdata[ULA_W-1:0];
                end
                if ((address == PAGING_PORT) && !lock_reg)
                begin
                    lock_next    = wdata[LOCK_BIT];
                    rom_sel_next = wdata[ROMSEL_BIT];
                    ram_sel_next = wdata[BANK_W-1:0];
                    screen_next  = wdata[SCREEN_BIT] ? SCREEN_HI : SCREEN_LO;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            rom_sel_reg <= 1'b0;
            ram_sel_reg <= '0;
            screen_reg  <= SCREEN_LO;
            lock_reg    <= 1'b0;
            ula_reg     <= '0;
            rd_sel_reg  <= RD_ZERO;
        end
        else
        begin
            if (accept)
            begin
                valid_reg   <= 1'b1;
                rom_sel_reg <= rom_sel_next;
                ram_sel_reg <= ram_sel_next;
                screen_reg  <= screen_next;
                lock_reg    <= lock_next;
                ula_reg     <= ula_next;
                rd_sel_reg  <= rd_sel_next;
            end
            else if (rsp_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            contended_reg <= cont_c;
        end
    end

    bmm_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .ram_q (ram_q),
        .rom_q (rom_q)
    );

    always_comb
    begin
        case (rd_sel_reg)
            RD_RAM:  rdata = ram_q;
            RD_ROM:  rdata = rom_q;
            default: rdata = '0;
        endcase
    end

    assign rsp_valid     = valid_reg;
    assign contended     = contended_reg;
    assign rom_bank      = rom_sel_reg;
    assign ram_bank      = ram_sel_reg;
    assign screen_bank   = screen_reg;
    assign paging_locked = lock_reg;
    assign border_color  = ula_reg[2:0];
    assign ear_bit       = ula_reg[EAR_BIT];
    assign mic_bit       = ula_reg[MIC_BIT];

    a_lock_holds: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |=> lock_reg && $stable(ram_sel_reg) && $stable(rom_sel_reg)
                     && $stable(screen_reg))
        else $error("paging changed while locked");

    a_screen_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (screen_reg == SCREEN_LO) || (screen_reg == SCREEN_HI))
        else $error("display bank neither 5 nor 7");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd_c == CMD_LOAD) |=> !contended_reg && (rd_sel_reg == RD_ZERO))
        else $error("ROM load gave contention or read data");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd_c != CMD_READ) |=> rsp_valid && (rdata == '0))
        else $error("non-read word returned data");

endmodule
